@@ design/parking_sequencer_pd_steer_assert.svh @@
// Assertion helpers for the parking sequencer.
`ifndef PARKING_SEQUENCER_PD_STEER_ASSERT_SVH
`define PARKING_SEQUENCER_PD_STEER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PSTEER_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSTEER_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/psteer_pkg.sv @@
`timescale 1ns / 1ps

package psteer_pkg;

  // Field widths
  localparam int unsigned OffsetW = 16;
  localparam int unsigned RangeW  = 14;
  localparam int unsigned ElapsedW = 10;
  localparam int unsigned GainW   = 16;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned SteerW  = 8;
  localparam int unsigned SpeedW  = 10;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] CFG_STEER_GAIN_P = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_STEER_GAIN_D = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_SPEED_GAIN   = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_SPACE_THR    = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_WALL_THR     = 3'd4;
  localparam logic [CfgAddrW-1:0] CFG_ALIGN_TIME   = 3'd5;

  // Mode codes as reported in the result word
  localparam logic [ModeW-1:0] MODE_LANE    = 2'd0;
  localparam logic [ModeW-1:0] MODE_ALIGN   = 2'd1;
  localparam logic [ModeW-1:0] MODE_REVERSE = 2'd2;
  localparam logic [ModeW-1:0] MODE_PARKED  = 2'd3;

  // Steering and speed commands
  localparam logic [SteerW-1:0]        STEER_MIN     = 8'd45;
  localparam logic [SteerW-1:0]        STEER_MID     = 8'd90;
  localparam logic [SteerW-1:0]        STEER_MAX     = 8'd135;
  localparam logic signed [SpeedW-1:0] SPEED_REVERSE = 10'sd250;
  localparam logic signed [SpeedW-1:0] SPEED_STOP    = 10'sd0;
  localparam logic [SpeedW-1:0]        SPEED_FWD_MAG = 10'd435;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_LANE    = 4'b0001,
    ST_ALIGN   = 4'b0010,
    ST_REVERSE = 4'b0100,
    ST_PARKED  = 4'b1000
  } state_e;

  // Control-law gains
  typedef struct packed {
    logic [GainW-1:0] steer_gain_p;
    logic [GainW-1:0] steer_gain_d;
    logic [GainW-1:0] speed_gain;
  } gains_t;

  // Control-law commands
  typedef struct packed {
    logic [SteerW-1:0]        steer;
    logic signed [SpeedW-1:0] speed;
  } pd_cmd_t;

endpackage

@@ design/psteer_pd_law.sv @@
`timescale 1ns / 1ps

module psteer_pd_law (
  input  psteer_pkg::gains_t                         gains_i,
  input  logic signed [psteer_pkg::OffsetW-1:0]      offset_i,
  input  logic signed [psteer_pkg::OffsetW-1:0]      prev_offset_i,
  output psteer_pkg::pd_cmd_t                        cmd_o
);

  logic signed [16:0] diff;
  logic signed [32:0] prod_p;
  logic signed [33:0] prod_d;
  logic signed [32:0] prod_s;
  logic signed [34:0] acc;
  logic signed [34:0] acc_adj;
  logic signed [22:0] u_angle;
  logic signed [32:0] prod_s_adj;
  logic signed [20:0] u_speed;
  logic [20:0]        speed_mag;

  // Form the P, D and speed products
  assign diff   = 17'(offset_i) - 17'(prev_offset_i);
  assign prod_p = $signed({1'b0, gains_i.steer_gain_p}) * offset_i;
  assign prod_d = $signed({1'b0, gains_i.steer_gain_d}) * diff;
  assign prod_s = $signed({1'b0, gains_i.speed_gain}) * offset_i;

  // Sum and scale by 1/4096, rounding toward zero
  assign acc        = 35'(prod_p) + 35'(prod_d);
  assign acc_adj    = acc + (acc[34] ? 35'sd4095 : 35'sd0);
  assign u_angle    = acc_adj[34:12];
  assign prod_s_adj = prod_s + (prod_s[32] ? 33'sd4095 : 33'sd0);
  assign u_speed    = prod_s_adj[32:12];
  assign speed_mag  = u_speed[20] ? 21'(-u_speed) : 21'(u_speed);

  // Clamp steering around center and speed to forward range
  always_comb begin
    if (u_angle < -23'sd45) begin
      cmd_o.steer = psteer_pkg::STEER_MIN;
    end else if (u_angle > 23'sd45) begin
      cmd_o.steer = psteer_pkg::STEER_MAX;
    end else begin
      cmd_o.steer = psteer_pkg::STEER_MID + u_angle[7:0];
    end
    if (speed_mag >= 21'(psteer_pkg::SPEED_FWD_MAG)) begin
      cmd_o.speed = psteer_pkg::SPEED_STOP;
    end else begin
      cmd_o.speed = $signed(speed_mag[9:0] - psteer_pkg::SPEED_FWD_MAG);
    end
  end

endmodule

@@ design/parking_sequencer_pd_steer.sv @@
`timescale 1ns / 1ps
// Parking sequencer with PD lane steering.
// Sample words enter on s_axis (offset, right range, rear range, elapsed ms);
// one command word per sample leaves on m_axis (steer, speed, mode).
// Gains, thresholds and align time are written through the cfg channel,
// which is always ready; write it only while no sample is in flight.
// A sample lands in the input register at acceptance; its command is
// registered once the output word is free. Throughput: one sample per
// cycle unless the receiver stalls; the control law (three multiplies, the
// clamps and the mode compares) sits between the input and output registers.
// Reset clears the mode to lane driving, the previous offset, the align
// timer and the one-shot space flag, and reloads the default gains.
// When the receiver stalls, the output word holds and the input register
// keeps one more sample; s_axis_tready_o drops once both are full.
`include "parking_sequencer_pd_steer_assert.svh"

module parking_sequencer_pd_steer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Config write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [psteer_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [psteer_pkg::CfgDataW-1:0]   cfg_data_i,
  // Sample stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [15:0] centre_offset, [29:16] right_range_mm, [43:30] rear_range_mm,
  // [53:44] elapsed_ms, [55:54] zero
  input  logic [55:0]                       s_axis_tdata_i,
  // Command stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [7:0] steer_angle, [17:8] drive_speed, [19:18] mode, [23:20] zero
  output logic [23:0]                       m_axis_tdata_o
);

  // Config registers
  psteer_pkg::gains_t                  gains_q;
  logic [psteer_pkg::RangeW-1:0]       space_thr_q;
  logic [psteer_pkg::RangeW-1:0]       wall_thr_q;
  logic [psteer_pkg::TimeW-1:0]        align_time_q;

  // Pipeline registers
  logic                                in_valid_q;
  logic signed [psteer_pkg::OffsetW-1:0] in_offset_q;
  logic [psteer_pkg::RangeW-1:0]       in_right_q;
  logic [psteer_pkg::RangeW-1:0]       in_rear_q;
  logic [psteer_pkg::ElapsedW-1:0]     in_elapsed_q;
  logic                                out_valid_q;
  logic [psteer_pkg::SteerW-1:0]       out_steer_q, out_steer_d;
  logic signed [psteer_pkg::SpeedW-1:0] out_speed_q, out_speed_d;
  logic [psteer_pkg::ModeW-1:0]        out_mode_q, out_mode_d;

  // Sequencer state
  psteer_pkg::state_e                  state_q, state_d;
  logic signed [psteer_pkg::OffsetW-1:0] prev_offset_q, prev_offset_d;
  logic [psteer_pkg::TimeW-1:0]        align_timer_q, align_timer_d;
  logic                                space_seen_q, space_seen_d;

  logic                                advance;
  logic                                enter_align;
  logic [psteer_pkg::TimeW:0]          timer_sum;
  logic [psteer_pkg::TimeW-1:0]        timer_next;
  psteer_pkg::pd_cmd_t                 pd_cmd;

  assign cfg_ready_o     = 1'b1;
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_mode_q, out_speed_q, out_steer_q};

  // Write config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.steer_gain_p <= 16'd3379;
      gains_q.steer_gain_d <= 16'd122;
      gains_q.speed_gain   <= 16'd5179;
      space_thr_q          <= 14'd250;
      wall_thr_q           <= 14'd100;
      align_time_q         <= 16'd600;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        psteer_pkg::CFG_STEER_GAIN_P: gains_q.steer_gain_p <= cfg_data_i;
        psteer_pkg::CFG_STEER_GAIN_D: gains_q.steer_gain_d <= cfg_data_i;
        psteer_pkg::CFG_SPEED_GAIN:   gains_q.speed_gain   <= cfg_data_i;
        psteer_pkg::CFG_SPACE_THR:    space_thr_q          <= cfg_data_i[13:0];
        psteer_pkg::CFG_WALL_THR:     wall_thr_q           <= cfg_data_i[13:0];
        psteer_pkg::CFG_ALIGN_TIME:   align_time_q         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control law
  psteer_pd_law u_pd_law (
    .gains_i       (gains_q),
    .offset_i      (in_offset_q),
    .prev_offset_i (prev_offset_q),
    .cmd_o         (pd_cmd)
  );

  // Align timer, saturating add
  assign timer_sum  = 17'(align_timer_q) + 17'(in_elapsed_q);
  assign timer_next = timer_sum[16] ? 16'hFFFF : timer_sum[15:0];
  assign enter_align = (state_q == psteer_pkg::ST_LANE) && !space_seen_q &&
                       (in_right_q > space_thr_q);

  // Sequence next state and command for the sample in the input register
  always_comb begin
    state_d       = state_q;
    prev_offset_d = prev_offset_q;
    align_timer_d = align_timer_q;
    space_seen_d  = space_seen_q;
    out_steer_d   = psteer_pkg::STEER_MID;
    out_speed_d   = psteer_pkg::SPEED_STOP;
    case (state_q)
      psteer_pkg::ST_LANE: begin
        out_steer_d   = pd_cmd.steer;
        out_speed_d   = pd_cmd.speed;
        prev_offset_d = in_offset_q;
        if (enter_align) begin
          space_seen_d  = 1'b1;
          align_timer_d = '0;
          state_d       = (align_time_q == '0) ? psteer_pkg::ST_REVERSE
                                               : psteer_pkg::ST_ALIGN;
        end
      end
      psteer_pkg::ST_ALIGN: begin
        out_steer_d   = pd_cmd.steer;
        out_speed_d   = pd_cmd.speed;
        prev_offset_d = in_offset_q;
        align_timer_d = timer_next;
        if (timer_next >= align_time_q) begin
          state_d = psteer_pkg::ST_REVERSE;
        end
      end
      psteer_pkg::ST_REVERSE: begin
        if (in_rear_q < wall_thr_q) begin
          state_d = psteer_pkg::ST_PARKED;
        end else begin
          out_steer_d = psteer_pkg::STEER_MIN;
          out_speed_d = psteer_pkg::SPEED_REVERSE;
        end
      end
      psteer_pkg::ST_PARKED: ;
      default: state_d = psteer_pkg::ST_LANE;
    endcase
    case (state_d)
      psteer_pkg::ST_ALIGN:   out_mode_d = psteer_pkg::MODE_ALIGN;
      psteer_pkg::ST_REVERSE: out_mode_d = psteer_pkg::MODE_REVERSE;
      psteer_pkg::ST_PARKED:  out_mode_d = psteer_pkg::MODE_PARKED;
      default:                out_mode_d = psteer_pkg::MODE_LANE;
    endcase
  end

  // Track occupancy of input and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the accepted sample word
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_offset_q  <= $signed(s_axis_tdata_i[15:0]);
      in_right_q   <= s_axis_tdata_i[29:16];
      in_rear_q    <= s_axis_tdata_i[43:30];
      in_elapsed_q <= s_axis_tdata_i[53:44];
    end
  end

  // Register the command word
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_steer_q <= out_steer_d;
      out_speed_q <= out_speed_d;
      out_mode_q  <= out_mode_d;
    end
  end

  // Advance sequencer state once per processed sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= psteer_pkg::ST_LANE;
      prev_offset_q <= '0;
      align_timer_q <= '0;
      space_seen_q  <= 1'b0;
    end else if (advance) begin
      state_q       <= state_d;
      prev_offset_q <= prev_offset_d;
      align_timer_q <= align_timer_d;
      space_seen_q  <= space_seen_d;
    end
  end

  // Checks
  `PSTEER_ASSERT_NXT(a_parked_sticks, clk_i, rst_ni,
    state_q == psteer_pkg::ST_PARKED, state_q == psteer_pkg::ST_PARKED,
    "parked state left")
  `PSTEER_ASSERT_NXT(a_space_seen_sticks, clk_i, rst_ni,
    space_seen_q, space_seen_q, "space flag cleared")
  `PSTEER_ASSERT_IMP(a_align_needs_space, clk_i, rst_ni,
    state_q != psteer_pkg::ST_LANE, space_seen_q, "left lane mode without a space")
  `PSTEER_ASSERT_IMP(a_parked_cmd, clk_i, rst_ni,
    out_valid_q && out_mode_q == psteer_pkg::MODE_PARKED,
    out_steer_q == psteer_pkg::STEER_MID && out_speed_q == psteer_pkg::SPEED_STOP,
    "parked word carries wrong command")
  `PSTEER_ASSERT_IMP(a_forward_speed, clk_i, rst_ni,
    out_valid_q && (out_mode_q == psteer_pkg::MODE_LANE ||
                    out_mode_q == psteer_pkg::MODE_ALIGN),
    out_speed_q[9] || out_speed_q == psteer_pkg::SPEED_STOP,
    "forward mode with reverse speed")

endmodule

@@ bench/parking_sequencer_pd_steer_tb.sv @@
`timescale 1ns / 1ps

module parking_sequencer_pd_steer_tb;

  // Q4.12 unity gain and the signed limits of the control law
  localparam longint GainOne  = 4096;
  localparam longint AngleLo  = longint'(psteer_pkg::STEER_MIN);
  localparam longint AngleMid = longint'(psteer_pkg::STEER_MID);
  localparam longint AngleHi  = longint'(psteer_pkg::STEER_MAX);
  localparam longint FwdMag   = longint'(psteer_pkg::SPEED_FWD_MAG);
  localparam int     RangeTop = 10000;
  localparam longint TimerMax = 65535;

  typedef struct {
    logic signed [psteer_pkg::OffsetW-1:0] offset;
    logic [psteer_pkg::RangeW-1:0]         right_mm;
    logic [psteer_pkg::RangeW-1:0]         rear_mm;
    logic [psteer_pkg::ElapsedW-1:0]       elapsed_ms;
  } sample_t;

  typedef struct {
    logic [psteer_pkg::SteerW-1:0]        steer;
    logic signed [psteer_pkg::SpeedW-1:0] speed;
    logic [psteer_pkg::ModeW-1:0]         mode;
  } command_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [psteer_pkg::CfgAddrW-1:0] cfg_addr_i = '0;
  logic [psteer_pkg::CfgDataW-1:0] cfg_data_i = '0;

  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;

  parking_sequencer_pd_steer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the sequencer: registers and state
  logic [psteer_pkg::GainW-1:0]  gain_p = 16'd3379;
  logic [psteer_pkg::GainW-1:0]  gain_d = 16'd122;
  logic [psteer_pkg::GainW-1:0]  gain_speed = 16'd5179;
  logic [psteer_pkg::RangeW-1:0] space_mm = 14'd250;
  logic [psteer_pkg::RangeW-1:0] wall_mm = 14'd100;
  logic [psteer_pkg::TimeW-1:0]  align_limit_ms = 16'd600;
  logic [psteer_pkg::ModeW-1:0]  mode_now = psteer_pkg::MODE_LANE;
  longint                        last_offset = 0;
  longint                        align_ms = 0;
  logic                          space_taken = 1'b0;

  sample_t  sample_queue[$];
  command_t command_expect[$];
  sample_t  cur_sample;
  int       send_idle = 0;
  int       recv_stall = 0;
  logic     send_steady = 1'b0;
  logic     recv_steady = 1'b0;
  int       fail_cnt = 0;

  // Work out the command word for one accepted sample and advance the shadow state
  function automatic void predict_command(sample_t smp);
    longint   off;
    longint   acc;
    longint   ang;
    longint   spd_u;
    longint   spd;
    logic     entered;
    command_t cmd;
    off = longint'(smp.offset);
    entered = 1'b0;
    cmd.steer = psteer_pkg::STEER_MID;
    cmd.speed = psteer_pkg::SPEED_STOP;
    // one-shot space detection comes before the mode action
    if (mode_now == psteer_pkg::MODE_LANE && !space_taken && smp.right_mm > space_mm) begin
      space_taken = 1'b1;
      align_ms = 0;
      mode_now = psteer_pkg::MODE_ALIGN;
      entered = 1'b1;
    end
    case (mode_now)
      psteer_pkg::MODE_LANE, psteer_pkg::MODE_ALIGN: begin
        acc = longint'(gain_p) * off + longint'(gain_d) * (off - last_offset);
        ang = AngleMid + acc / GainOne;
        if (ang < AngleLo) ang = AngleLo;
        if (ang > AngleHi) ang = AngleHi;
        spd_u = (longint'(gain_speed) * off) / GainOne;
        if (spd_u < 0) spd_u = -spd_u;
        spd = spd_u - FwdMag;
        if (spd > 0) spd = 0;
        cmd.steer = ang[psteer_pkg::SteerW-1:0];
        cmd.speed = spd[psteer_pkg::SpeedW-1:0];
        last_offset = off;
        if (mode_now == psteer_pkg::MODE_ALIGN) begin
          // the sample that opens align mode adds no time
          if (!entered) begin
            align_ms += longint'(smp.elapsed_ms);
            if (align_ms > TimerMax) align_ms = TimerMax;
          end
          if (align_ms >= longint'(align_limit_ms)) mode_now = psteer_pkg::MODE_REVERSE;
        end
      end
      psteer_pkg::MODE_REVERSE: begin
        cmd.steer = psteer_pkg::STEER_MIN;
        cmd.speed = psteer_pkg::SPEED_REVERSE;
        if (smp.rear_mm < wall_mm) begin
          cmd.steer = psteer_pkg::STEER_MID;
          cmd.speed = psteer_pkg::SPEED_STOP;
          mode_now = psteer_pkg::MODE_PARKED;
        end
      end
      default: begin
      end
    endcase
    cmd.mode = mode_now;
    command_expect = {command_expect, cmd};
  endfunction

  // Present sample words, one idle draw per word
  always @(posedge clk_i) begin : drive_samples
    logic    nxt_valid;
    sample_t nxt;
    nxt_valid = s_axis_tvalid_i;
    nxt = cur_sample;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_command(cur_sample);
        nxt_valid = 1'b0;
        send_idle = send_steady ? 0 : int'($urandom_range(0, 5));
      end
      if (!nxt_valid) begin
        if (send_idle > 0) begin
          send_idle--;
        end else if (sample_queue.size() > 0) begin
          nxt = sample_queue.pop_front();
          nxt_valid = 1'b1;
        end
      end
    end
    s_axis_tvalid_i <= nxt_valid;
    cur_sample <= nxt;
    s_axis_tdata_i <= {2'b00, nxt.elapsed_ms, nxt.rear_mm, nxt.right_mm, nxt.offset};
  end

  // Take command words, stall at random, compare against the oldest expectation
  always @(posedge clk_i) begin : check_commands
    logic     nxt_ready;
    command_t got;
    command_t want;
    nxt_ready = m_axis_tready_i;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.steer = m_axis_tdata_o[7:0];
        got.speed = m_axis_tdata_o[17:8];
        got.mode  = m_axis_tdata_o[19:18];
        if (command_expect.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: unexpected command word steer=%0d speed=%0d mode=%0d",
                     $realtime, got.steer, got.speed, got.mode);
        end else begin
          want = command_expect.pop_front();
          if (got.steer != want.steer || got.speed != want.speed || got.mode != want.mode)
          begin
            fail_cnt++;
            // steer/speed/mode
            if (fail_cnt <= 10)
              $display("%0t: command mismatch exp %0d/%0d/%0d got %0d/%0d/%0d",
                       $realtime, want.steer, want.speed, want.mode,
                       got.steer, got.speed, got.mode);
          end
        end
        recv_stall = recv_steady ? 0 : int'($urandom_range(0, 5));
      end
      if (recv_stall > 0) begin
        recv_stall--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
    end
    m_axis_tready_i <= nxt_ready;
  end

  // Write one register and mirror it into the shadow copy
  task automatic write_reg(input logic [psteer_pkg::CfgAddrW-1:0] idx,
                           input logic [psteer_pkg::CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      psteer_pkg::CFG_STEER_GAIN_P: gain_p = value;
      psteer_pkg::CFG_STEER_GAIN_D: gain_d = value;
      psteer_pkg::CFG_SPEED_GAIN:   gain_speed = value;
      psteer_pkg::CFG_SPACE_THR:    space_mm = value[psteer_pkg::RangeW-1:0];
      psteer_pkg::CFG_WALL_THR:     wall_mm = value[psteer_pkg::RangeW-1:0];
      psteer_pkg::CFG_ALIGN_TIME:   align_limit_ms = value;
      default: begin
      end
    endcase
  endtask

  task automatic set_config(input int gp, input int gd, input int gs,
                            input int space, input int wall, input int align);
    write_reg(psteer_pkg::CFG_STEER_GAIN_P, gp[15:0]);
    write_reg(psteer_pkg::CFG_STEER_GAIN_D, gd[15:0]);
    write_reg(psteer_pkg::CFG_SPEED_GAIN, gs[15:0]);
    write_reg(psteer_pkg::CFG_SPACE_THR, space[15:0]);
    write_reg(psteer_pkg::CFG_WALL_THR, wall[15:0]);
    write_reg(psteer_pkg::CFG_ALIGN_TIME, align[15:0]);
  endtask

  // Hold the sender until every command word is back, then let the pipe settle
  task automatic drain_commands();
    do @(negedge clk_i);
    while (sample_queue.size() != 0 || s_axis_tvalid_i || command_expect.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic pick_idling();
    send_steady = ($urandom_range(0, 3) == 0);
    recv_steady = ($urandom_range(0, 3) == 0);
  endtask

  function automatic sample_t mk(input int off, input int right, input int rear, input int el);
    sample_t s;
    s.offset = off[psteer_pkg::OffsetW-1:0];
    s.right_mm = right[psteer_pkg::RangeW-1:0];
    s.rear_mm = rear[psteer_pkg::RangeW-1:0];
    s.elapsed_ms = el[psteer_pkg::ElapsedW-1:0];
    return s;
  endfunction

  function automatic int rand_offset();
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 400)) - 200;
      1: begin
        case ($urandom_range(0, 3))
          0: return -32768;
          1: return 32767;
          2: return -1;
          default: return 0;
        endcase
      end
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic sample_t rand_sample(input int right_hi);
    return mk(rand_offset(), int'($urandom_range(0, right_hi)),
              int'($urandom_range(0, RangeTop)), int'($urandom_range(0, 1023)));
  endfunction

  function automatic int pick_gain();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 65535 : 0;
      1: return int'($urandom_range(0, 8191));
      default: return int'($urandom_range(0, 65535));
    endcase
  endfunction

  // Lane driving with random gains; the space threshold sits at the top of the range
  task automatic lane_phase(input int n, input bit split);
    set_config(pick_gain(), pick_gain(), pick_gain(), RangeTop,
               int'($urandom_range(0, RangeTop)), int'($urandom_range(0, 65535)));
    pick_idling();
    @(negedge clk_i);
    repeat (split ? n / 2 : n) sample_queue = {sample_queue, rand_sample(RangeTop)};
    if (split) begin
      drain_commands();
      repeat (n - n / 2) sample_queue = {sample_queue, rand_sample(RangeTop)};
    end
    drain_commands();
  endtask

  initial begin : run_test
    int thr;
    int wall;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset gains, offset extremes, rounding toward zero
    pick_idling();
    sample_queue = {sample_queue, mk(0, 0, 0, 0)};
    sample_queue = {sample_queue, mk(-32768, 250, RangeTop, 1023)};
    sample_queue = {sample_queue, mk(32767, 0, 0, 0)};
    sample_queue = {sample_queue, mk(1, 100, 5000, 512)};
    sample_queue = {sample_queue, mk(-1, 200, 8191, 511)};
    sample_queue = {sample_queue, mk(-4096, 0, 1, 1)};
    sample_queue = {sample_queue, mk(4096, 0, 2, 2)};
    sample_queue = {sample_queue, mk(100, 0, 3, 3)};
    sample_queue = {sample_queue, mk(-100, 0, 4, 4)};
    sample_queue = {sample_queue, mk(55, 0, 5, 5)};
    sample_queue = {sample_queue, mk(-56, 0, 6, 6)};
    drain_commands();

    // Directed: largest gains; a right range equal to the threshold is no space
    set_config(65535, 65535, 65535, RangeTop, RangeTop, 0);
    @(negedge clk_i);
    sample_queue = {sample_queue, mk(32767, RangeTop, RangeTop, 1023)};
    sample_queue = {sample_queue, mk(-32768, RangeTop, 0, 0)};
    sample_queue = {sample_queue, mk(1, 0, 0, 0)};
    sample_queue = {sample_queue, mk(-1, 0, 0, 0)};
    sample_queue = {sample_queue, mk(0, 0, 0, 0)};
    drain_commands();

    // Directed: zero gains
    set_config(0, 0, 0, RangeTop, 0, 65535);
    @(negedge clk_i);
    sample_queue = {sample_queue, mk(32767, 0, 0, 0)};
    sample_queue = {sample_queue, mk(-32768, 0, 0, 0)};
    sample_queue = {sample_queue, mk(123, 0, 0, 0)};
    drain_commands();

    // Random lane driving under several gain settings
    for (int ph = 0; ph < 6; ph++) lane_phase(120, ph == 2);

    // Parking run: lane, then a space opens align mode
    thr = int'($urandom_range(200, 5000));
    set_config(pick_gain(), pick_gain(), pick_gain(), thr, 0, 65535);
    pick_idling();
    @(negedge clk_i);
    repeat (30) sample_queue = {sample_queue, rand_sample(thr)};
    sample_queue = {sample_queue, mk(rand_offset(), thr, 0, 1023)};
    sample_queue = {sample_queue, mk(rand_offset(), thr + 1, RangeTop, 1023)};
    repeat (60) sample_queue = {sample_queue, rand_sample(RangeTop)};
    drain_commands();

    // Run the align timer into saturation; a zero wall threshold keeps reversing
    pick_idling();
    @(negedge clk_i);
    repeat (120) sample_queue = {sample_queue,
                                 mk(rand_offset(), int'($urandom_range(0, RangeTop)),
                                    int'($urandom_range(0, RangeTop)),
                                    int'($urandom_range(800, 1023)))};
    drain_commands();

    // Raise the wall threshold: equal range keeps reversing, a lower one parks
    wall = int'($urandom_range(1000, 8000));
    write_reg(psteer_pkg::CFG_WALL_THR, wall[15:0]);
    pick_idling();
    @(negedge clk_i);
    sample_queue = {sample_queue, mk(rand_offset(), 0, wall, 0)};
    sample_queue = {sample_queue, mk(rand_offset(), 0, RangeTop, 0)};
    repeat (40) sample_queue = {sample_queue, rand_sample(RangeTop)};
    drain_commands();

    // Parked stays parked whatever the registers say
    set_config(65535, 65535, 65535, 0, RangeTop, 0);
    pick_idling();
    @(negedge clk_i);
    sample_queue = {sample_queue, mk(0, RangeTop, 0, 1023)};
    repeat (20) sample_queue = {sample_queue, rand_sample(RangeTop)};
    drain_commands();

    repeat (10) @(negedge clk_i);
    if (fail_cnt == 0 && command_expect.size() == 0) begin
      $display("** parking_sequencer_pd_steer: PASSED **");
    end else begin
      $display("** parking_sequencer_pd_steer: FAILED **");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin : watchdog
    #2000000;
    $display("** parking_sequencer_pd_steer: FAILED **");
    $finish;
  end

endmodule
